>>> src/procedural_codebook_decoder_core_macros.svh
// Assertion macros for the codebook decoder
`ifndef PROCEDURAL_CODEBOOK_DECODER_CORE_MACROS_SVH
`define PROCEDURAL_CODEBOOK_DECODER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define PCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define PCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> src/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared constants and types of the procedural codebook decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package pcd_pkg;
   typedef enum logic [1:0] {
      MODE_DEFAULT = 2'd0,
      MODE_MCG     = 2'd1,
      MODE_MUL1    = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   localparam logic [31:0] MUL_DEFAULT = 32'd89226354;
   localparam logic [31:0] ADD_DEFAULT = 32'd64248484;
   localparam logic [31:0] MUL_MCG     = 32'hcbac1fed;
   localparam logic [31:0] MUL_MUL1    = 32'h83dcd12d;
   localparam logic [31:0] AND_MASK    = 32'h8fff8fff;
   localparam logic [31:0] XOR_MASK    = 32'h3b603b60;
   localparam logic [15:0] NAN_HALF    = 16'h7e00;
   localparam logic [10:0] SCALE_MANT  = 11'd1774;
   localparam logic [21:0] OFF_TERM    = 22'd2721792; // 1329*2048

   // magnitude with binary point below bit K; width MAG_W
   localparam int MAG_W = 23;

   typedef struct packed {
      logic             valid;
      mode_type         mode;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic             mul1;  // scale 2^-18, else 2^-13
   } mag_stage_type;
endpackage
`default_nettype wire

>>> src/pcd_mix.sv
// ----------------------------------------------------------------------------
// pcd_mix
// Multiply stage and word-to-magnitude stage.
// ----------------------------------------------------------------------------
`default_nettype none
module pcd_mix (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [15:0]           in_word,
   input  wire pcd_pkg::mode_type     in_mode,
   output pcd_pkg::mag_stage_type     out_stage
);
   logic                  v1_ff;
   pcd_pkg::mode_type     m1_ff;
   logic [31:0]           w1_ff, w1_in;
   pcd_pkg::mag_stage_type st_in, st_ff;

   logic [31:0] mixed;
   logic [13:0] va, vb;
   logic signed [15:0] s;
   logic [9:0]  nsum;
   logic [21:0] prod;
   logic signed [22:0] ms;

   always_comb begin
      unique case (in_mode)
         pcd_pkg::MODE_DEFAULT:
            w1_in = in_word * pcd_pkg::MUL_DEFAULT + pcd_pkg::ADD_DEFAULT;
         pcd_pkg::MODE_MCG:  w1_in = in_word * pcd_pkg::MUL_MCG;
         default:            w1_in = in_word * pcd_pkg::MUL_MUL1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
      m1_ff <= in_mode;
      w1_ff <= w1_in;
   end

   always_comb begin
      mixed = pcd_pkg::XOR_MASK ^ (w1_ff & pcd_pkg::AND_MASK);
      // exponent field is 12..15, so up to 2047 << 3
      va = 14'({1'b1, mixed[9:0]}) << mixed[11:10];
      vb = 14'({1'b1, mixed[25:16]}) << mixed[27:26];
      s = (mixed[15] ? -$signed({2'b0, va}) : $signed({2'b0, va}))
        + (mixed[31] ? -$signed({2'b0, vb}) : $signed({2'b0, vb}));
      nsum = 10'(w1_ff[7:0]) + 10'(w1_ff[15:8]) + 10'(w1_ff[23:16])
           + 10'(w1_ff[31:24]);
      prod = 22'({1'b1, nsum} * pcd_pkg::SCALE_MANT);
      ms = $signed({1'b0, prod}) - $signed({1'b0, pcd_pkg::OFF_TERM});
      st_in.valid = v1_ff;
      st_in.mode  = m1_ff;
      if (m1_ff == pcd_pkg::MODE_MUL1) begin
         st_in.mul1 = 1'b1;
         st_in.neg  = ms[22];
         st_in.mag  = ms[22] ? 23'(-ms) : 23'(ms);
      end else begin
         st_in.mul1 = 1'b0;
         st_in.neg  = s[15];
         st_in.mag  = s[15] ? 23'(-s) : 23'(s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff.valid <= 1'b0;
      else       st_ff.valid <= st_in.valid;
      st_ff.mode <= st_in.mode;
      st_ff.neg  <= st_in.neg;
      st_ff.mag  <= st_in.mag;
      st_ff.mul1 <= st_in.mul1;
   end
   assign out_stage = st_ff;
endmodule
`default_nettype wire

>>> src/pcd_round.sv
// ----------------------------------------------------------------------------
// pcd_round
// Normalize and round a fixed-point magnitude to half, nearest even.
// ----------------------------------------------------------------------------
`default_nettype none
`include "procedural_codebook_decoder_core_macros.svh"
module pcd_round (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcd_pkg::mag_stage_type in_stage,
   output logic                       out_valid,
   output logic [15:0]                out_half
);
   localparam int W = pcd_pkg::MAG_W;
   // stage A: leading-one position
   pcd_pkg::mag_stage_type a_ff;
   logic [4:0] p_ff, p_in;
   logic       z_ff;

   always_comb begin
      p_in = '0;
      for (int i = 0; i < W; i++)
         if (in_stage.mag[i]) p_in = 5'(i);
   end

   always_ff @(posedge clock) begin
      if (reset) a_ff.valid <= 1'b0;
      else       a_ff.valid <= in_stage.valid;
      a_ff.mode <= in_stage.mode;
      a_ff.neg  <= in_stage.neg;
      a_ff.mag  <= in_stage.mag;
      a_ff.mul1 <= in_stage.mul1;
      p_ff      <= p_in;
      z_ff      <= (in_stage.mag == '0);
   end

   // stage B: shift, round, pack
   logic signed [6:0] e, q, drop;
   logic [W-1:0] r, rem, halfway, lowmask;
   logic [W:0]   rr;
   logic [16:0]  bits;
   logic [15:0]  res_in, res_ff;
   logic         v_ff;

   always_comb begin
      e = $signed({2'b0, p_ff}) - (a_ff.mul1 ? 7'sd18 : 7'sd13);
      q = e - 7'sd10;
      if (q < -7'sd24) q = -7'sd24;
      drop = q + (a_ff.mul1 ? 7'sd18 : 7'sd13);
      r = '0; rem = '0; halfway = '0; lowmask = '0; rr = '0;
      if (drop > 0) begin
         lowmask = (W'(1) << drop[4:0]) - W'(1);
         rem     = a_ff.mag & lowmask;
         halfway = W'(1) << (drop[4:0] - 5'd1);
         r       = a_ff.mag >> drop[4:0];
         rr      = {1'b0, r};
         if (rem > halfway || (rem == halfway && r[0])) rr = rr + (W+1)'(1);
      end else begin
         rr = {1'b0, a_ff.mag << (-drop)};
      end
      if (e >= -7'sd14) bits = 17'(e + 7'sd14) * 17'd1024 + 17'(rr);
      else              bits = 17'(rr);
      if (bits >= 17'h7c00) bits = 17'h7c00;
      if (a_ff.mode == pcd_pkg::MODE_NONE) res_in = pcd_pkg::NAN_HALF;
      else if (z_ff)                      res_in = 16'h0000;
      else res_in = bits[15:0] | (a_ff.neg ? 16'h8000 : 16'h0000);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else       v_ff <= a_ff.valid;
      res_ff <= res_in;
   end
   assign out_valid = v_ff;
   assign out_half  = res_ff;

   `PCD_ASSERT_NEXT(a_pass_valid, clock, reset, a_ff.valid, v_ff, "valid lost in round")
   `PCD_ASSERT_NEXT(a_no_spurious, clock, reset, !a_ff.valid, !v_ff, "spurious result")
   `PCD_ASSERT_IMPL(a_zero_lead, clock, reset, a_ff.valid && z_ff, p_ff == 5'd0, "lead bad")
endmodule
`default_nettype wire

>>> src/procedural_codebook_decoder_core.sv
// Path: an accepted start passes the multiply, mix, leading-one and round registers before the rsp_valid strobe.
// Throughput: one transaction per cycle; busy is always low.
// Stages: multiply, mix/byte-sum, leading-one search, round and pack.
// Reset: synchronous, active high; clears valid bits and sets mode 0.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// procedural_codebook_decoder_core
// Top level: trellis state to half-precision weight, three codebooks.
// ----------------------------------------------------------------------------
`default_nettype none
module procedural_codebook_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_state_word,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_codebook_mode,
   output logic             rsp_valid,
   output logic [15:0]      rsp_weight_half
);
   // mode register; the user must write it only while idle, the block does not enforce this
   pcd_pkg::mode_type mode_ff;
   always_ff @(posedge clock) begin
      if (reset)                 mode_ff <= pcd_pkg::MODE_DEFAULT;
      else if (csr_write_enable) mode_ff <= pcd_pkg::mode_type'(csr_codebook_mode);
   end

   // fully pipelined: never busy
   assign busy = 1'b0;

   pcd_pkg::mag_stage_type mag_stage;

   pcd_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_word   (req_state_word),
      .in_mode   (mode_ff),
      .out_stage (mag_stage)
   );

   pcd_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (mag_stage),
      .out_valid (rsp_valid),
      .out_half  (rsp_weight_half)
   );
endmodule
`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the codebook decoder: a local half-precision model
// predicts each weight, a monitor compares strobed results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_state_word = '0;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_codebook_mode = '0;
   logic        rsp_valid;
   logic [15:0] rsp_weight_half;

   procedural_codebook_decoder_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_state_word(req_state_word),
      .csr_write_enable(csr_write_enable), .csr_codebook_mode(csr_codebook_mode),
      .rsp_valid(rsp_valid), .rsp_weight_half(rsp_weight_half)
   );

   always #10 clock = ~clock;

   // Stimulus side: words waiting to go, mode shadow used when each is sent
   logic [15:0] pending_words[$];
   logic [15:0] weight_queue[$];
   pcd_pkg::mode_type active_mode = pcd_pkg::MODE_DEFAULT;
   int          gap_pct = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   bit          running = 1'b0;

   // Round (-1)^neg * mag * 2^-k to half precision, nearest even.
   function automatic logic [15:0] round_half(bit neg, logic [63:0] mag, int k);
      int p, e, q, drop;
      logic [63:0] r, rem, halfway;
      logic [31:0] bits;
      if (mag == 0) return 16'h0000;
      p = 63;
      while (mag[p] == 1'b0) p--;
      e = p - k;
      q = (e - 10 < -24) ? -24 : e - 10;
      drop = q + k;
      if (drop > 0) begin
         rem = mag & ((64'd1 << drop) - 1);
         halfway = 64'd1 << (drop - 1);
         r = mag >> drop;
         if (rem > halfway || (rem == halfway && r[0])) r++;
      end else begin
         r = mag << (-drop);
      end
      bits = (e >= -14) ? (32'(e + 14) * 1024 + 32'(r)) : 32'(r);
      if (bits >= 32'h7c00) bits = 32'h7c00;
      return bits[15:0] | (neg ? 16'h8000 : 16'h0000);
   endfunction

   // Half with exponent 12..15 as a signed count of 2^-13
   function automatic longint half_units(logic [15:0] h);
      longint v;
      v = longint'({1'b1, h[9:0]}) << h[11:10];
      return h[15] ? -v : v;
   endfunction

   function automatic logic [15:0] predict_weight(pcd_pkg::mode_type m, logic [15:0] w);
      logic [31:0] prod, mixed, n;
      longint s;
      case (m)
         pcd_pkg::MODE_DEFAULT, pcd_pkg::MODE_MCG: begin
            prod = (m == pcd_pkg::MODE_DEFAULT)
                 ? 32'(w) * pcd_pkg::MUL_DEFAULT + pcd_pkg::ADD_DEFAULT
                 : 32'(w) * pcd_pkg::MUL_MCG;
            mixed = pcd_pkg::XOR_MASK ^ (prod & pcd_pkg::AND_MASK);
            s = half_units(mixed[15:0]) + half_units(mixed[31:16]);
            return (s < 0) ? round_half(1'b1, 64'(-s), 13) : round_half(1'b0, 64'(s), 13);
         end
         pcd_pkg::MODE_MUL1: begin
            prod = 32'(w) * pcd_pkg::MUL_MUL1;
            n = 32'h6400 + prod[7:0] + prod[15:8] + prod[23:16] + prod[31:24];
            n = (n & 32'h3ff) | 32'h400;
            s = longint'(n) * 1774 - longint'(1329) * 2048;
            return (s < 0) ? round_half(1'b1, 64'(-s), 18) : round_half(1'b0, 64'(s), 18);
         end
         default: return pcd_pkg::NAN_HALF;
      endcase
   endfunction

   // Driver: start follows the queue; idles at random per gap_pct
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            weight_queue.push_back(predict_weight(active_mode, req_state_word));
            void'(pending_words.pop_front());
         end
         // head of queue may have just been popped; decide next cycle's drive
         if (pending_words.size() > 0 && (!start || !busy) &&
             $urandom_range(99) >= gap_pct) begin
            start <= 1'b1;
            req_state_word <= pending_words[0];
         end else if (!start || !busy) begin
            start <= 1'b0;
            req_state_word <= 16'($urandom);
         end
      end
   end

   // Monitor: every strobe must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (weight_queue.size() == 0) begin
            $error("unexpected weight_half %h", rsp_weight_half);
            fail_count++;
         end else begin
            logic [15:0] exp_w;
            exp_w = weight_queue.pop_front();
            if (exp_w !== rsp_weight_half) begin
               $error("weight_half: expected %h actual %h", exp_w, rsp_weight_half);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: cycles without any accepted transaction or result strobe
   always @(posedge clock) begin
      if (running) begin
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 5000) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_words.size() > 0 || start || weight_queue.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_mode(pcd_pkg::mode_type m);
      csr_write_enable <= 1'b1;
      csr_codebook_mode <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_mode = m;
   endtask

   task automatic run_phase(pcd_pkg::mode_type m, int count);
      set_mode(m);
      // directed extremes first
      pending_words.push_back(16'h0000);
      pending_words.push_back(16'hffff);
      pending_words.push_back(16'h8000);
      pending_words.push_back(16'h0001);
      pending_words.push_back(16'h5555);
      pending_words.push_back(16'haaaa);
      repeat (count) pending_words.push_back(16'($urandom));
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      running = 1'b1;
      @(posedge clock);
      // reset mode 0 checked before any write
      pending_words.push_back(16'h1234);
      drain();
      gap_pct = 37;
      run_phase(pcd_pkg::MODE_DEFAULT, 120);
      run_phase(pcd_pkg::MODE_MUL1, 120);
      run_phase(pcd_pkg::MODE_NONE, 30);
      gap_pct = 82;
      run_phase(pcd_pkg::MODE_MCG, 120);
      run_phase(pcd_pkg::MODE_DEFAULT, 80);
      gap_pct = 0;
      run_phase(pcd_pkg::MODE_MUL1, 200);
      run_phase(pcd_pkg::MODE_MCG, 200);
      run_phase(pcd_pkg::MODE_DEFAULT, 200);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
